// ===== rtl/lfsa_pkg.sv =====
// Shared types and constants of the lowest-free-slot handle allocator.
// Used by lfsa_scan and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package lfsa_pkg;

  // The occupancy bitmap is kept in rows of this many slots.
  localparam int CHUNK_W  = 16;
  localparam int CHUNK_IW = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  // What the current row evaluation is doing.
  typedef enum logic [1:0] {
    M_GAP    = 2'd0,
    M_APPEND = 2'd1,
    M_FREE   = 2'd2,
    M_DOWN   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] vec;
    logic               from_top;
  } scan_req_t;

  typedef struct packed {
    logic                found;
    logic [CHUNK_IW-1:0] idx;
  } scan_res_t;

endpackage

// ===== rtl/lfsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the occupancy bitmap rows; no dependencies.
`timescale 1ns / 1ps

module lfsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lfsa_scan.sv =====
// Shared priority encoder of one bitmap row: finds the lowest or highest set bit.
// Depends on lfsa_pkg.
`timescale 1ns / 1ps

module lfsa_scan (
  input  lfsa_pkg::scan_req_t req,
  output lfsa_pkg::scan_res_t res
);

  always_comb begin
    res.found = |req.vec;
    res.idx   = '0;
    if (req.from_top) begin
      for (int i = 0; i < lfsa_pkg::CHUNK_W; i++) begin
        if (req.vec[i]) begin
          res.idx = lfsa_pkg::CHUNK_IW'(i);
        end
      end
    end else begin
      for (int i = lfsa_pkg::CHUNK_W - 1; i >= 0; i--) begin
        if (req.vec[i]) begin
          res.idx = lfsa_pkg::CHUNK_IW'(i);
        end
      end
    end
  end

endmodule

// ===== rtl/lowest_free_slot_handle_allocator_unit.sv =====
// Top level of the lowest-free-slot handle allocator.
// Depends on lfsa_pkg, lfsa_ram (bitmap rows) and lfsa_scan (row encoder).
`timescale 1ns / 1ps

// Usage
// The input stream carries one command per beat: s_tuser holds the command
// (allocate, free, clear) and s_tdata the one-based handle to free. Every
// command yields exactly one output beat: m_tuser holds the status and
// m_tdata the new handle, the occupied count and the highest handle.
// The occupancy bitmap sits in a small RAM of 16-slot rows. A single
// priority encoder is reused row after row by a four-state sequencer, and
// the block takes one command at a time (s_tready is high only when idle).
// Clear and the unused command code go straight from accept to the result load.
// An append allocate or a free of a handle below the top takes one row
// read, one evaluate/write and one result load. An allocate that fills a
// gap repeats the row read and evaluate for each row scanned upward;
// freeing the highest handle repeats them for each row walked downward to
// find the next occupied slot (at most SLOT_COUNT/16 rounded up rows). The
// RAM read port and the shared encoder make the scan go row by row.
// Reset clears the row valid bits, the count and the top handle at once, so
// no clearing pass is needed; a clear command does the same.
// If the receiver stalls, the result waits in the output register and the
// block holds in its result state; no beat is lost or repeated.
module lowest_free_slot_handle_allocator_unit #(
  parameter int SLOT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] handle, [7] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] new_handle, [13:7] used_count,
                                 // [20:14] highest_handle, [23:21] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int CW     = $clog2(SLOT_COUNT + 1);
  localparam int ROWS   = (SLOT_COUNT + lfsa_pkg::CHUNK_W - 1) / lfsa_pkg::CHUNK_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW     = ROW_W + lfsa_pkg::CHUNK_IW;
  localparam int CMPW   = (CW > 7) ? CW : 7;
  localparam int CIW    = lfsa_pkg::CHUNK_IW;
  localparam int CWD    = lfsa_pkg::CHUNK_W;

  lfsa_pkg::state_t  state;
  lfsa_pkg::mode_t   mode;
  lfsa_pkg::status_t status;

  logic [CW-1:0]    count;
  logic [CW-1:0]    top;
  logic [CW-1:0]    given;
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] row;
  logic [CIW-1:0]   bitsel;
  logic             hit_top;

  // Handle and top handle compared at a width that holds both.
  logic [CMPW-1:0]  h_ext;
  logic [CMPW-1:0]  top_ext;
  logic [IW-1:0]    free_idx;
  logic [IW-1:0]    top_idx;
  logic             free_bad;

  logic [CWD-1:0]   rd_data;
  logic [CWD-1:0]   word;
  logic [CWD-1:0]   bit_mask;
  logic [CWD-1:0]   cleared;
  logic             wr_en;
  logic [CWD-1:0]   wr_data;
  logic [CW-1:0]    hit_handle;

  lfsa_pkg::scan_req_t scan_req;
  lfsa_pkg::scan_res_t scan_res;

  assign s_tready = (state == lfsa_pkg::S_IDLE);

  assign h_ext    = CMPW'(s_tdata[6:0]);
  assign top_ext  = CMPW'(top);
  assign free_idx = IW'(h_ext - CMPW'(1));
  assign top_idx  = IW'(top);
  assign free_bad = (count == '0) || (h_ext == '0) || (h_ext > top_ext) ||
                    (h_ext > CMPW'(SLOT_COUNT));

  // A row whose valid bit is clear reads as all free.
  assign word     = row_valid[row] ? rd_data : '0;
  assign bit_mask = CWD'(1) << bitsel;
  assign cleared  = word & ~bit_mask;

  always_comb begin
    case (mode)
      lfsa_pkg::M_GAP: begin
        scan_req.vec      = ~word;
        scan_req.from_top = 1'b0;
      end
      lfsa_pkg::M_FREE: begin
        scan_req.vec      = cleared;
        scan_req.from_top = 1'b1;
      end
      default: begin
        scan_req.vec      = word;
        scan_req.from_top = 1'b1;
      end
    endcase
  end

  lfsa_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  assign hit_handle = CW'({row, scan_res.idx}) + CW'(1);

  // Row write-back happens in the evaluate cycle of allocate and free.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = word;
    if (state == lfsa_pkg::S_EV) begin
      case (mode)
        lfsa_pkg::M_GAP: begin
          wr_en   = scan_res.found;
          wr_data = word | (CWD'(1) << scan_res.idx);
        end
        lfsa_pkg::M_APPEND: begin
          wr_en   = 1'b1;
          wr_data = word | bit_mask;
        end
        lfsa_pkg::M_FREE: begin
          wr_en   = word[bitsel];
          wr_data = cleared;
        end
        default: begin
          wr_en   = 1'b0;
          wr_data = word;
        end
      endcase
    end
  end

  lfsa_ram #(
    .WIDTH (CWD),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row),
    .wr_data (wr_data),
    .rd_en   (state == lfsa_pkg::S_RD),
    .rd_addr (row),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfsa_pkg::S_IDLE;
      m_tvalid  <= 1'b0;
      row_valid <= '0;
      count     <= '0;
      top       <= '0;
    end else begin
      // In the result state the output register is handled below.
      if (m_tvalid && m_tready && state != lfsa_pkg::S_RESP) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        row_valid[row] <= 1'b1;
      end
      case (state)
        lfsa_pkg::S_IDLE: begin
          if (s_tvalid) begin
            given   <= '0;
            status  <= lfsa_pkg::ST_OK;
            hit_top <= (h_ext == top_ext);
            state   <= lfsa_pkg::S_RESP;
            case (lfsa_pkg::cmd_t'(s_tuser))
              lfsa_pkg::CMD_ALLOC: begin
                if (count != top) begin
                  mode  <= lfsa_pkg::M_GAP;
                  row   <= '0;
                  state <= lfsa_pkg::S_RD;
                end else if (top >= CW'(SLOT_COUNT)) begin
                  status <= lfsa_pkg::ST_FULL;
                end else begin
                  mode   <= lfsa_pkg::M_APPEND;
                  row    <= top_idx[IW-1:CIW];
                  bitsel <= top_idx[CIW-1:0];
                  state  <= lfsa_pkg::S_RD;
                end
              end
              lfsa_pkg::CMD_FREE: begin
                if (free_bad) begin
                  status <= lfsa_pkg::ST_BAD;
                end else begin
                  mode   <= lfsa_pkg::M_FREE;
                  row    <= free_idx[IW-1:CIW];
                  bitsel <= free_idx[CIW-1:0];
                  state  <= lfsa_pkg::S_RD;
                end
              end
              lfsa_pkg::CMD_CLEAR: begin
                row_valid <= '0;
                count     <= '0;
                top       <= '0;
              end
              default: begin
                // The unused command code leaves everything as it is.
              end
            endcase
          end
        end
        lfsa_pkg::S_RD: begin
          state <= lfsa_pkg::S_EV;
        end
        lfsa_pkg::S_EV: begin
          state <= lfsa_pkg::S_RESP;
          case (mode)
            lfsa_pkg::M_GAP: begin
              if (scan_res.found) begin
                count <= count + CW'(1);
                given <= hit_handle;
              end else begin
                row   <= row + ROW_W'(1);
                state <= lfsa_pkg::S_RD;
              end
            end
            lfsa_pkg::M_APPEND: begin
              count <= count + CW'(1);
              top   <= top + CW'(1);
              given <= top + CW'(1);
            end
            lfsa_pkg::M_FREE: begin
              if (!word[bitsel]) begin
                status <= lfsa_pkg::ST_BAD;
              end else begin
                count <= count - CW'(1);
                if (hit_top) begin
                  // The cleared row itself is the first place to look.
                  if (scan_res.found) begin
                    top <= hit_handle;
                  end else if (row == '0) begin
                    top <= '0;
                  end else begin
                    row   <= row - ROW_W'(1);
                    mode  <= lfsa_pkg::M_DOWN;
                    state <= lfsa_pkg::S_RD;
                  end
                end
              end
            end
            default: begin
              if (scan_res.found) begin
                top <= hit_handle;
              end else if (row == '0) begin
                top <= '0;
              end else begin
                row   <= row - ROW_W'(1);
                state <= lfsa_pkg::S_RD;
              end
            end
          endcase
        end
        lfsa_pkg::S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= {3'b000, 7'(top), 7'(count), 7'(given)};
            state    <= lfsa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lfsa_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
